### rtl/core/tryptic_digest_peptide_mass_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tryptic digest block
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRYPTIC_DIGEST_PEPTIDE_MASS_DEFINES_SVH
`define TRYPTIC_DIGEST_PEPTIDE_MASS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tdpm_pkg.sv
// ----------------------------------------------------------------------------
// tdpm_pkg
// Types, constants and the residue mass table of the tryptic digest block.
// ----------------------------------------------------------------------------
package tdpm_pkg;

  localparam int MAX_MISSED = 3;
  localparam int DEPTH      = MAX_MISSED + 1;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int RES_W   = 5;
  localparam int POS_W   = 16;
  localparam int MASS_W  = 41;
  localparam int LINK_W  = 16;
  localparam int MISS_W  = 2;
  localparam int RMASS_W = 25;

  localparam logic [POS_W-1:0] MAX_LENGTH = 16'd65535;

  localparam logic [RES_W-1:0] CODE_B = 5'd1;
  localparam logic [RES_W-1:0] CODE_K = 5'd10;
  localparam logic [RES_W-1:0] CODE_P = 5'd15;
  localparam logic [RES_W-1:0] CODE_R = 5'd17;
  localparam logic [RES_W-1:0] CODE_X = 5'd23;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_REG_MISSED = 1'b0;  // word index held in paddr[2]

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT_A,
    S_UPDATE,
    S_EMIT_B,
    S_FLUSH
  } state_t;

  // One stored cleavage boundary.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [MASS_W-1:0] mass;
    logic [LINK_W-1:0] links;
    logic              valid;
  } bnd_t;

  // Running prefix broadcast to every cell.
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [MASS_W-1:0] mass;
    logic [LINK_W-1:0] links;
  } pfx_t;

  // Peptide candidate that a cell offers from its boundary to the prefix.
  typedef struct packed {
    logic              ok;
    logic [POS_W-1:0]  pos;
    logic [MASS_W-1:0] mass;
    logic              xl;
  } cand_t;

  typedef struct packed {
    logic push;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0]  begin_pos;
    logic [POS_W-1:0]  end_pos;
    logic [MASS_W-1:0] peptide_mass;
    logic              has_crosslinker;
    logic [MISS_W-1:0] missed_count;
    logic              last_of_run;
  } pep_t;

  // Monoisotopic residue masses, 16 fractional bits. Unknown codes weigh zero.
  function automatic logic [RMASS_W-1:0] residue_mass(input logic [RES_W-1:0] code);
    logic [RMASS_W-1:0] m;
    case (code)
      5'd0:    m = 25'd4655488;
      5'd1:    m = 25'd16455736;
      5'd2:    m = 25'd6750810;
      5'd3:    m = 25'd7538406;
      5'd4:    m = 25'd8456935;
      5'd5:    m = 25'd9638276;
      5'd6:    m = 25'd3736959;
      5'd7:    m = 25'd8982293;
      5'd8:    m = 25'd7411077;
      5'd9:    m = 25'd7506162;
      5'd10:   m = 25'd8394831;
      5'd11:   m = 25'd7411077;
      5'd12:   m = 25'd8587869;
      5'd13:   m = 25'd7473917;
      5'd15:   m = 25'd6360450;
      5'd16:   m = 25'd8392447;
      5'd17:   m = 25'd10230242;
      5'd18:   m = 25'd5703731;
      5'd19:   m = 25'd6622261;
      5'd20:   m = 25'd9892898;
      5'd21:   m = 25'd6492547;
      5'd22:   m = 25'd12194894;
      5'd23:   m = 25'd29699610;
      5'd24:   m = 25'd10686518;
      5'd25:   m = 25'd8424691;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/tdpm_if.sv
// ----------------------------------------------------------------------------
// tdpm_in_if / tdpm_out_if
// Valid/ready channels for residue items and peptide items.
// ----------------------------------------------------------------------------
interface tdpm_in_if;
  logic                       valid;
  logic                       ready;
  logic [tdpm_pkg::RES_W-1:0] residue;
  logic                       final_residue;

  modport source (output valid, residue, final_residue, input ready);
  modport sink   (input valid, residue, final_residue, output ready);
endinterface

interface tdpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [tdpm_pkg::POS_W-1:0]  begin_pos;
  logic [tdpm_pkg::POS_W-1:0]  end_pos;
  logic [tdpm_pkg::MASS_W-1:0] peptide_mass;
  logic                        has_crosslinker;
  logic [tdpm_pkg::MISS_W-1:0] missed_count;
  logic                        last_of_run;

  modport source (output valid, begin_pos, end_pos, peptide_mass, has_crosslinker,
                  missed_count, last_of_run, input ready);
  modport sink   (input valid, begin_pos, end_pos, peptide_mass, has_crosslinker,
                  missed_count, last_of_run, output ready);
endinterface

### rtl/core/tdpm_cell.sv
// ----------------------------------------------------------------------------
// tdpm_cell
// One boundary cell: holds a cleavage boundary, shifts it to the next older
// cell on a push and offers the peptide from its boundary to the prefix.
// ----------------------------------------------------------------------------
module tdpm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tdpm_pkg::cell_ctl_t ctl,
  input  logic                first_cell,
  input  tdpm_pkg::pfx_t      cur,
  input  tdpm_pkg::bnd_t      nb_in,
  output tdpm_pkg::bnd_t      bnd_out,
  output tdpm_pkg::cand_t     cand
);

  tdpm_pkg::bnd_t bnd_r;

  // After a clear only the newest cell holds a boundary, at position zero.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      bnd_r <= '{pos: '0, mass: '0, links: '0, valid: first_cell};
    end else if (ctl.push) begin
      bnd_r <= nb_in;
    end
  end

  assign bnd_out = bnd_r;

  always_comb begin
    cand.ok   = bnd_r.valid && (bnd_r.pos < cur.pos);
    cand.pos  = bnd_r.pos;
    cand.mass = cur.mass - bnd_r.mass;
    cand.xl   = (cur.links != bnd_r.links);
  end

endmodule

### rtl/core/tdpm_cfg.sv
// ----------------------------------------------------------------------------
// tdpm_cfg
// APB-style register port holding the missed cleavage limit.
// ----------------------------------------------------------------------------
module tdpm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tdpm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [tdpm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [tdpm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output logic [tdpm_pkg::IDX_W-1:0]  allow
);

  logic [tdpm_pkg::MISS_W-1:0] missed_r;
  logic [tdpm_pkg::MISS_W-1:0] missed_nxt;
  logic                        hit;

  assign cfg_pready = 1'b1;
  assign hit        = (cfg_paddr[2] == tdpm_pkg::CFG_REG_MISSED);

  always_comb begin
    missed_nxt = missed_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit) begin
      missed_nxt = cfg_pwdata[tdpm_pkg::MISS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      missed_r <= '0;
    end else begin
      missed_r <= missed_nxt;
    end
  end

  assign cfg_prdata = hit ? tdpm_pkg::CFG_DW'(missed_r) : '0;

  // The limit saturates at MAX_MISSED, one less than the depth of the boundary chain.
  assign allow = (32'(missed_r) > tdpm_pkg::MAX_MISSED)
               ? tdpm_pkg::IDX_W'(tdpm_pkg::MAX_MISSED)
               : tdpm_pkg::IDX_W'(missed_r);

endmodule

### rtl/core/tryptic_digest_peptide_mass.sv
// ----------------------------------------------------------------------------
// tryptic_digest_peptide_mass
// Streaming trypsin digest: cleaves after K or R not followed by P and emits
// peptides over a chain of boundary cells, with up to three missed cleavages.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        residue, final_residue
//   out_ch   out  valid/ready        begin_pos, end_pos, peptide_mass,
//                                    has_crosslinker, missed_count, last_of_run
//   cfg_*    in   psel/penable (APB) missed_allowed at byte address 0
//
// An item with no cleavage and no protein end passes through accept and update.
// A cleavage adds a scan over the boundary cells up to missed_allowed before the
// update, and a closing step that hands over the last peptide; a protein end adds
// a scan after the update and the same closing step, which also clears the stream.
// Output stalls hold the scan and the closing step in place. Reset is synchronous;
// one boundary at position zero is valid after it.
// ----------------------------------------------------------------------------
`include "tryptic_digest_peptide_mass_defines.svh"

module tryptic_digest_peptide_mass (
  input  logic                        clk,
  input  logic                        rst_n,
  tdpm_in_if.sink                     in_ch,
  tdpm_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tdpm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [tdpm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [tdpm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int DEPTH = tdpm_pkg::DEPTH;
  localparam int IDX_W = tdpm_pkg::IDX_W;

  tdpm_pkg::state_t state_r, state_nxt;

  logic [tdpm_pkg::POS_W-1:0]  position_r, position_nxt;
  logic [tdpm_pkg::MASS_W-1:0] prefix_r, prefix_nxt;
  logic [tdpm_pkg::LINK_W-1:0] links_r, links_nxt;
  logic                        prev_cleavable_r, prev_cleavable_nxt;
  logic [tdpm_pkg::RES_W-1:0]  res_r, res_nxt;
  logic                        fin_r, fin_nxt;
  logic                        cleave_r, cleave_nxt;
  logic [IDX_W-1:0]            j_r, j_nxt;
  tdpm_pkg::pep_t              hold_r, hold_nxt;
  logic                        hold_valid_r, hold_valid_nxt;
  tdpm_pkg::pep_t              out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0]    allow;
  logic                accept;
  logic                out_free;
  logic                emitting;
  logic                produce;
  logic                last_j;
  logic                step_go;
  logic                do_update;
  logic                take_pep;
  logic                move_hold;
  logic                move_last;
  logic                pep_ordered;
  logic                end_flush;
  logic                stream_clear;
  tdpm_pkg::cell_ctl_t cell_ctl;
  tdpm_pkg::pfx_t      cur;
  tdpm_pkg::bnd_t      head;
  tdpm_pkg::bnd_t      bnd_out [DEPTH];
  tdpm_pkg::cand_t     cand    [DEPTH];
  tdpm_pkg::cand_t     cs;
  tdpm_pkg::pep_t      new_pep;

  tdpm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .allow       (allow)
  );

  assign cur  = '{pos: position_r, mass: prefix_r, links: links_r};
  assign head = '{pos: position_r, mass: prefix_r, links: links_r, valid: 1'b1};

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    tdpm_pkg::bnd_t nb;
    if (k == 0) begin : g_head
      assign nb = head;
    end else begin : g_tail
      assign nb = bnd_out[k-1];
    end
    tdpm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .first_cell ((k == 0) ? 1'b1 : 1'b0),
      .cur        (cur),
      .nb_in      (nb),
      .bnd_out    (bnd_out[k]),
      .cand       (cand[k])
    );
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign emitting = (state_r == tdpm_pkg::S_EMIT_A) || (state_r == tdpm_pkg::S_EMIT_B);
  assign cs       = cand[j_r];
  assign produce  = cs.ok;
  assign last_j   = (j_r == allow) || (32'(j_r) == DEPTH - 1);
  // A new peptide pushes the held one out, so it needs a free output register.
  assign step_go  = emitting && (!produce || !hold_valid_r || out_free);

  assign new_pep = '{begin_pos:       cs.pos,
                     end_pos:         position_r,
                     peptide_mass:    cs.mass,
                     has_crosslinker: cs.xl,
                     missed_count:    tdpm_pkg::MISS_W'(j_r),
                     last_of_run:     1'b0};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdpm_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = cleave_nxt ? tdpm_pkg::S_EMIT_A : tdpm_pkg::S_UPDATE;
        end
      end
      tdpm_pkg::S_EMIT_A: begin
        if (step_go && last_j) begin
          state_nxt = tdpm_pkg::S_UPDATE;
        end
      end
      tdpm_pkg::S_UPDATE: begin
        if (fin_r) begin
          state_nxt = tdpm_pkg::S_EMIT_B;
        end else if (hold_valid_r) begin
          state_nxt = tdpm_pkg::S_FLUSH;
        end else begin
          state_nxt = tdpm_pkg::S_IDLE;
        end
      end
      tdpm_pkg::S_EMIT_B: begin
        if (step_go && last_j) begin
          state_nxt = tdpm_pkg::S_FLUSH;
        end
      end
      tdpm_pkg::S_FLUSH: begin
        if (!hold_valid_r || out_free) begin
          state_nxt = tdpm_pkg::S_IDLE;
        end
      end
      default: state_nxt = tdpm_pkg::S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready    = 1'b0;
    do_update      = 1'b0;
    take_pep       = 1'b0;
    move_hold      = 1'b0;
    move_last      = 1'b0;
    cell_ctl.push  = 1'b0;
    cell_ctl.clear = 1'b0;
    unique case (state_r)
      tdpm_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      tdpm_pkg::S_EMIT_A, tdpm_pkg::S_EMIT_B: begin
        take_pep  = step_go && produce;
        move_hold = step_go && produce && hold_valid_r;
      end
      tdpm_pkg::S_UPDATE: begin
        do_update     = 1'b1;
        cell_ctl.push = cleave_r;
      end
      tdpm_pkg::S_FLUSH: begin
        cell_ctl.clear = fin_r;
        move_hold      = hold_valid_r && out_free;
        move_last      = 1'b1;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Datapath.
  always_comb begin
    position_nxt       = position_r;
    prefix_nxt         = prefix_r;
    links_nxt          = links_r;
    prev_cleavable_nxt = prev_cleavable_r;
    res_nxt            = res_r;
    fin_nxt            = fin_r;
    cleave_nxt         = cleave_r;
    j_nxt              = j_r;
    hold_nxt           = hold_r;
    hold_valid_nxt     = hold_valid_r;
    out_nxt            = out_r;
    out_valid_nxt      = out_valid_r && !out_ch.ready;

    if (accept) begin
      res_nxt    = in_ch.residue;
      fin_nxt    = in_ch.final_residue;
      cleave_nxt = prev_cleavable_r && (in_ch.residue != tdpm_pkg::CODE_P)
                && (position_r != tdpm_pkg::MAX_LENGTH);
    end

    if (step_go) begin
      j_nxt = last_j ? '0 : j_r + 1'b1;
    end

    // A residue at the length limit is dropped.
    if (do_update && (position_r != tdpm_pkg::MAX_LENGTH)) begin
      prefix_nxt         = prefix_r + tdpm_pkg::MASS_W'(tdpm_pkg::residue_mass(res_r));
      position_nxt       = position_r + 1'b1;
      prev_cleavable_nxt = (res_r == tdpm_pkg::CODE_K) || (res_r == tdpm_pkg::CODE_R);
      if ((res_r == tdpm_pkg::CODE_X) || (res_r == tdpm_pkg::CODE_B)) begin
        links_nxt = links_r + 1'b1;
      end
    end

    if (move_hold) begin
      out_nxt             = hold_r;
      out_nxt.last_of_run = move_last;
      out_valid_nxt       = 1'b1;
      hold_valid_nxt      = 1'b0;
    end

    if (take_pep) begin
      hold_nxt       = new_pep;
      hold_valid_nxt = 1'b1;
    end

    if (cell_ctl.clear) begin
      position_nxt       = '0;
      prefix_nxt         = '0;
      links_nxt          = '0;
      prev_cleavable_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= tdpm_pkg::S_IDLE;
      position_r       <= '0;
      prefix_r         <= '0;
      links_r          <= '0;
      prev_cleavable_r <= 1'b0;
      fin_r            <= 1'b0;
      cleave_r         <= 1'b0;
      j_r              <= '0;
      hold_valid_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      position_r       <= position_nxt;
      prefix_r         <= prefix_nxt;
      links_r          <= links_nxt;
      prev_cleavable_r <= prev_cleavable_nxt;
      fin_r            <= fin_nxt;
      cleave_r         <= cleave_nxt;
      j_r              <= j_nxt;
      hold_valid_r     <= hold_valid_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.begin_pos       = out_r.begin_pos;
  assign out_ch.end_pos         = out_r.end_pos;
  assign out_ch.peptide_mass    = out_r.peptide_mass;
  assign out_ch.has_crosslinker = out_r.has_crosslinker;
  assign out_ch.missed_count    = out_r.missed_count;
  assign out_ch.last_of_run     = out_r.last_of_run;

  assign pep_ordered  = hold_r.begin_pos < hold_r.end_pos;
  assign end_flush    = (state_r == tdpm_pkg::S_FLUSH) && fin_r;
  assign stream_clear = (position_r == '0) && !prev_cleavable_r;

  `TDPM_ASSERT_NOW(a_idle_no_hold, state_r == tdpm_pkg::S_IDLE, !hold_valid_r, "hold busy in idle")
  `TDPM_ASSERT_NOW(a_pep_nonempty, hold_valid_r, pep_ordered, "empty peptide emitted")
  `TDPM_ASSERT_NOW(a_head_valid, 1'b1, bnd_out[0].valid, "newest boundary cell lost its valid bit")
  `TDPM_ASSERT_NEXT(a_end_clears, end_flush, stream_clear, "protein end did not clear the stream")

endmodule
